// ===== hdl/blol_pkg.sv =====
// shared types and constants for the bounded overwrite log list
package blol_pkg;

	localparam int ENTRIES_DEF = 16;

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_GET    = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	// one log record, user index in the top bits
	typedef struct packed {
		logic [7:0] user;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
	} log_rec_t;

	typedef enum logic [3:0] {
		CMD_IDLE,
		CMD_LOAD,
		CMD_HEAD,
		CMD_SCAN,
		CMD_ADVANCE,
		CMD_REMOVE,
		CMD_FETCH,
		CMD_LINK_A,
		CMD_LINK_B,
		CMD_CLEAR,
		CMD_EMIT
	} dp_cmd_t;

	typedef struct packed {
		logic scan_free;
		logic scan_last;
		logic cur_nil;
		logic user_match;
		logic in_range;
		logic steps_zero;
	} dp_status_t;

endpackage

// ===== hdl/blol_datapath.sv =====
// record store, link memory, list pointers and result registers
module blol_datapath import blol_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  func_t       func,
	input  log_rec_t    rec_in,
	input  logic [3:0]  position,
	output dp_status_t  status,
	output logic        ok,
	output logic        overwrote,
	output log_rec_t    rec_out,
	output logic [4:0]  entry_count
);

	localparam int SW   = $clog2(ENTRIES);
	localparam int LW   = $clog2(ENTRIES + 1);
	localparam int CW   = LW;
	localparam int CMPW = (CW > 4) ? CW : 4;
	localparam int EW   = CW + 5;
	localparam logic [LW-1:0] NIL = LW'(ENTRIES);

	log_rec_t          rec_mem  [ENTRIES];
	logic [LW-1:0]     next_mem [ENTRIES];

	log_rec_t          rec_rd;
	logic [LW-1:0]     next_rd;
	logic [SW-1:0]     rd_addr;

	logic              nx_we;
	logic [SW-1:0]     nx_waddr;
	logic [LW-1:0]     nx_wdata;

	logic [LW-1:0]     head_q, tail_q, cur_q, prv_q;
	logic [CW-1:0]     count_q;
	logic [ENTRIES-1:0] valid_q;
	logic [SW-1:0]     scan_q, slot_q;
	logic [3:0]        steps_q;
	log_rec_t          wrec_q, res_rec_q;
	logic              res_ok_q, res_over_q;
	logic [EW-1:0]     cnt_ext;

	// read address follows the walk: next link feeds straight back
	always_comb begin
		unique case (cmd)
			CMD_LOAD, CMD_HEAD:     rd_addr = head_q[SW-1:0];
			CMD_ADVANCE, CMD_REMOVE: rd_addr = next_rd[SW-1:0];
			default:                rd_addr = cur_q[SW-1:0];
		endcase
	end

	always_comb begin
		nx_we    = 1'b0;
		nx_waddr = slot_q;
		nx_wdata = NIL;
		unique case (cmd)
			CMD_LINK_A: begin
				nx_we    = 1'b1;
				nx_waddr = slot_q;
				nx_wdata = NIL;
			end
			CMD_LINK_B: begin
				nx_we    = (tail_q != NIL);
				nx_waddr = tail_q[SW-1:0];
				nx_wdata = LW'(slot_q);
			end
			CMD_REMOVE: begin
				nx_we    = (prv_q != NIL);
				nx_waddr = prv_q[SW-1:0];
				nx_wdata = next_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		rec_rd  <= rec_mem[rd_addr];
		next_rd <= next_mem[rd_addr];
		if (cmd == CMD_LINK_A) begin
			rec_mem[slot_q] <= wrec_q;
		end
		if (nx_we) begin
			next_mem[nx_waddr] <= nx_wdata;
		end
	end

	// list bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NIL;
			tail_q  <= NIL;
			count_q <= '0;
			valid_q <= '0;
		end else begin
			unique case (cmd)
				CMD_CLEAR: begin
					head_q  <= NIL;
					tail_q  <= NIL;
					count_q <= '0;
					valid_q <= '0;
				end
				CMD_REMOVE: begin
					valid_q[cur_q[SW-1:0]] <= 1'b0;
					count_q <= count_q - CW'(1);
					if (prv_q == NIL) begin
						head_q <= next_rd;
					end
					if (next_rd == NIL) begin
						tail_q <= prv_q;
					end
				end
				CMD_LINK_B: begin
					valid_q[slot_q] <= 1'b1;
					count_q <= count_q + CW'(1);
					if (tail_q == NIL) begin
						head_q <= LW'(slot_q);
					end
					tail_q <= LW'(slot_q);
				end
				default: ;
			endcase
		end
	end

	assign cnt_ext = EW'(count_q);

	// walk pointers and result words
	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LOAD: begin
				wrec_q     <= rec_in;
				steps_q    <= position;
				cur_q      <= head_q;
				prv_q      <= NIL;
				scan_q     <= '0;
				res_ok_q   <= (func == FUNC_ADD) || (func == FUNC_CLEAR);
				res_over_q <= 1'b0;
				res_rec_q  <= '0;
			end
			CMD_HEAD: begin
				cur_q      <= head_q;
				prv_q      <= NIL;
				res_over_q <= 1'b1;
			end
			CMD_SCAN: begin
				slot_q <= scan_q;
				scan_q <= scan_q + SW'(1);
			end
			CMD_ADVANCE: begin
				prv_q   <= cur_q;
				cur_q   <= next_rd;
				steps_q <= steps_q - 4'd1;
			end
			CMD_REMOVE: begin
				cur_q    <= next_rd;
				slot_q   <= cur_q[SW-1:0];
				res_ok_q <= 1'b1;
			end
			CMD_FETCH: begin
				res_rec_q <= rec_rd;
				res_ok_q  <= 1'b1;
			end
			CMD_EMIT: begin
				ok          <= res_ok_q;
				overwrote   <= res_over_q;
				rec_out     <= res_rec_q;
				entry_count <= cnt_ext[4:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		status.scan_free  = !valid_q[scan_q];
		status.scan_last  = (scan_q == SW'(ENTRIES - 1));
		status.cur_nil    = (cur_q == NIL);
		status.user_match = (rec_rd.user == wrec_q.user);
		status.in_range   = (CMPW'(steps_q) < CMPW'(count_q));
		status.steps_zero = (steps_q == 4'd0);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("held count above store size");

	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NIL) == (count_q == '0))
		else $error("head pointer disagrees with held count");

	a_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_q == NIL) == (count_q == '0))
		else $error("tail pointer disagrees with held count");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("valid bits disagree with held count");

endmodule

// ===== hdl/blol_ctrl.sv =====
// sequencer for add, remove, get and clear
module blol_ctrl import blol_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  func_t      func,
	output dp_cmd_t    cmd,
	input  dp_status_t status,
	output logic       out_valid,
	input  logic       out_ready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_OVER,
		ST_LINK_A,
		ST_LINK_B,
		ST_REMOVE,
		ST_GET,
		ST_CLEAR,
		ST_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		cmd     = CMD_IDLE;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd = CMD_LOAD;
					unique case (func)
						FUNC_ADD:    state_d = ST_SCAN;
						FUNC_REMOVE: state_d = ST_REMOVE;
						FUNC_GET:    state_d = ST_GET;
						FUNC_CLEAR:  state_d = ST_CLEAR;
					endcase
				end
			end
			ST_SCAN: begin
				priority if (status.scan_free) begin
					cmd     = CMD_SCAN;
					state_d = ST_LINK_A;
				end else if (status.scan_last) begin
					// store full: recycle the oldest slot
					cmd     = CMD_HEAD;
					state_d = ST_OVER;
				end else begin
					cmd = CMD_SCAN;
				end
			end
			ST_OVER: begin
				cmd     = CMD_REMOVE;
				state_d = ST_LINK_A;
			end
			ST_LINK_A: begin
				cmd     = CMD_LINK_A;
				state_d = ST_LINK_B;
			end
			ST_LINK_B: begin
				cmd     = CMD_LINK_B;
				state_d = ST_FINISH;
			end
			ST_REMOVE: begin
				priority if (status.cur_nil) begin
					state_d = ST_FINISH;
				end else if (status.user_match) begin
					cmd = CMD_REMOVE;
				end else begin
					cmd = CMD_ADVANCE;
				end
			end
			ST_GET: begin
				priority if (!status.in_range) begin
					state_d = ST_FINISH;
				end else if (status.steps_zero) begin
					cmd     = CMD_FETCH;
					state_d = ST_FINISH;
				end else begin
					cmd = CMD_ADVANCE;
				end
			end
			ST_CLEAR: begin
				cmd     = CMD_CLEAR;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd     = CMD_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd == CMD_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_EMIT) |-> (!out_valid_q || out_ready))
		else $error("result word written over an untaken one");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_EMIT) |=> (state_q == ST_IDLE) && out_valid_q)
		else $error("emit did not return to idle with a result");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_LOAD) |-> (in_valid && in_ready))
		else $error("item loaded without an accept");

endmodule

// ===== hdl/bounded_overwrite_log_list.sv =====
// bounded overwrite log list: linked log of time-stamped records, stream ports
// add scans the slots in turn up to the first free one, or recycles the oldest when full,
//   then links the record; remove walks every list node; get walks up to position
// throughput: one word at a time, taken only in idle; the free-slot scan and the node walk
//   go one slot or node per cycle through the registered link memory read
// reset: arst_n clears the list pointers, count and valid bits at once; no clearing pass
module bounded_overwrite_log_list import blol_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// user_id[7:0] month_in[11:8] day_in[16:12] hour_in[21:17] minute_in[27:22]
	// position[31:28]
	input  logic [31:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// ok[0] overwrote[1] user_out[9:2] month_out[13:10] day_out[18:14]
	// hour_out[23:19] minute_out[29:24] entry_count[34:30] zero[39:35]
	output logic [39:0] m_axis_tdata
);

	dp_cmd_t    cmd;
	dp_status_t status;
	func_t      func;
	log_rec_t   rec_in, rec_out;
	logic       ok, overwrote;
	logic [4:0] entry_count;

	assign func          = func_t'(s_axis_tuser);
	assign rec_in.user   = s_axis_tdata[7:0];
	assign rec_in.month  = s_axis_tdata[11:8];
	assign rec_in.day    = s_axis_tdata[16:12];
	assign rec_in.hour   = s_axis_tdata[21:17];
	assign rec_in.minute = s_axis_tdata[27:22];

	blol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.func      (func),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

	blol_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (func),
		.rec_in      (rec_in),
		.position    (s_axis_tdata[31:28]),
		.status      (status),
		.ok          (ok),
		.overwrote   (overwrote),
		.rec_out     (rec_out),
		.entry_count (entry_count)
	);

	assign m_axis_tdata = {5'd0, entry_count, rec_out.minute, rec_out.hour, rec_out.day,
		rec_out.month, rec_out.user, overwrote, ok};

endmodule
